// ===== rtl/core/rne_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, constants and step tables of the Roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

  localparam int unsigned VALUE_W        = 12;
  localparam int unsigned LETTER_W       = 7;
  localparam int unsigned STEP_W         = 4;
  localparam int unsigned NUM_STEPS      = 13;
  localparam int unsigned RNE_QUEUE_DEPTH = 2;

  localparam logic [LETTER_W-1:0] LETTER_I = 7'd73;
  localparam logic [LETTER_W-1:0] LETTER_V = 7'd86;
  localparam logic [LETTER_W-1:0] LETTER_X = 7'd88;
  localparam logic [LETTER_W-1:0] LETTER_L = 7'd76;
  localparam logic [LETTER_W-1:0] LETTER_C = 7'd67;
  localparam logic [LETTER_W-1:0] LETTER_D = 7'd68;
  localparam logic [LETTER_W-1:0] LETTER_M = 7'd77;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  // queue head as seen by the back part
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
  } rne_head_t;

  function automatic logic [VALUE_W-1:0] step_amount(input logic [STEP_W-1:0] idx);
    logic [VALUE_W-1:0] amt;
    case (idx)
      4'd0:    amt = 12'd1000;
      4'd1:    amt = 12'd900;
      4'd2:    amt = 12'd500;
      4'd3:    amt = 12'd400;
      4'd4:    amt = 12'd100;
      4'd5:    amt = 12'd90;
      4'd6:    amt = 12'd50;
      4'd7:    amt = 12'd40;
      4'd8:    amt = 12'd10;
      4'd9:    amt = 12'd9;
      4'd10:   amt = 12'd5;
      4'd11:   amt = 12'd4;
      default: amt = 12'd1;
    endcase
    return amt;
  endfunction

  function automatic logic [LETTER_W-1:0] step_first(input logic [STEP_W-1:0] idx);
    logic [LETTER_W-1:0] ch;
    case (idx)
      4'd0:    ch = LETTER_M;
      4'd1:    ch = LETTER_C;
      4'd2:    ch = LETTER_D;
      4'd3:    ch = LETTER_C;
      4'd4:    ch = LETTER_C;
      4'd5:    ch = LETTER_X;
      4'd6:    ch = LETTER_L;
      4'd7:    ch = LETTER_X;
      4'd8:    ch = LETTER_X;
      4'd9:    ch = LETTER_I;
      4'd10:   ch = LETTER_V;
      default: ch = LETTER_I;
    endcase
    return ch;
  endfunction

  function automatic logic [LETTER_W-1:0] step_second(input logic [STEP_W-1:0] idx);
    logic [LETTER_W-1:0] ch;
    case (idx)
      4'd1:    ch = LETTER_M;
      4'd3:    ch = LETTER_D;
      4'd5:    ch = LETTER_C;
      4'd7:    ch = LETTER_L;
      4'd9:    ch = LETTER_X;
      default: ch = LETTER_V;
    endcase
    return ch;
  endfunction

  // subtractive pairs sit at the odd steps
  function automatic logic step_has_second(input logic [STEP_W-1:0] idx);
    return idx[0] && (idx != LAST_STEP);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rne_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rne_front
// Accepts values, drops zeros, and queues the rest for the letter sequencer.
// ----------------------------------------------------------------------------
module rne_front
  import rne_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = RNE_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic               push,
  output logic                    full,
  output rne_head_t               head,
  input  wire logic               take
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [VALUE_W-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               wr;
  logic               rd;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  // zero gives no letters, so the transaction ends here
  assign wr   = push && !full && (value != '0);
  assign rd   = take && head.valid;

  assign head = '{valid: (count != '0), value: slots[rd_ptr]};

  always_comb begin
    case ({wr, rd})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_zero_dropped: assert property (@(posedge clk) disable iff (rst)
    push && !full && (value == '0) && !head.valid |=> !head.valid)
    else $error("zero value entered the queue");

  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    take |-> head.valid)
    else $error("take from empty queue");

endmodule
`default_nettype wire

// ===== rtl/core/rne_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rne_back
// Greedy letter sequencer with a one-entry result register.
// ----------------------------------------------------------------------------
module rne_back
  import rne_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rne_head_t           head,
  output logic                     take,
  output logic [LETTER_W-1:0]      letter,
  output logic                     last,
  output logic                     empty,
  input  wire logic                pop
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_SECOND = 3'b100
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [VALUE_W-1:0] remaining;
  logic [VALUE_W-1:0] remaining_next;
  logic [STEP_W-1:0]  step_index;
  logic [STEP_W-1:0]  step_index_next;
  logic [VALUE_W-1:0] amt;
  logic [VALUE_W-1:0] diff;
  logic               fits;
  logic               out_valid;
  logic               out_free;
  logic               emit;
  logic               emit_last;
  logic [LETTER_W-1:0] emit_letter;

  assign amt      = step_amount(step_index);
  assign fits     = (remaining >= amt);
  assign diff     = remaining - amt;
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  always_comb begin
    state_next      = state;
    remaining_next  = remaining;
    step_index_next = step_index;
    take            = 1'b0;
    emit            = 1'b0;
    emit_last       = 1'b0;
    emit_letter     = step_first(step_index);
    case (state)
      S_IDLE: begin
        if (head.valid) begin
          take            = 1'b1;
          remaining_next  = head.value;
          step_index_next = '0;
          state_next      = S_WALK;
        end
      end
      S_WALK: begin
        if (!fits) begin
          step_index_next = step_index + 1'b1;
        end else if (out_free) begin
          emit           = 1'b1;
          remaining_next = diff;
          if (step_has_second(step_index)) begin
            state_next = S_SECOND;
          end else if (diff == '0) begin
            emit_last  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_SECOND: begin
        emit_letter = step_second(step_index);
        if (out_free) begin
          emit = 1'b1;
          if (remaining == '0) begin
            emit_last  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      remaining  <= '0;
      step_index <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      remaining  <= remaining_next;
      step_index <= step_index_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      letter <= emit_letter;
      last   <= emit_last;
    end
  end

  a_walk_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> remaining != '0)
    else $error("walking with nothing left");

  a_second_pair: assert property (@(posedge clk) disable iff (rst)
    state == S_SECOND |-> step_has_second(step_index))
    else $error("second letter on a single-letter step");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    emit && emit_last |=> state == S_IDLE)
    else $error("last letter without return to idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> !out_valid || pop)
    else $error("result overwritten before pop");

endmodule
`default_nettype wire

// ===== rtl/core/roman_numeral_encoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// roman_numeral_encoder_core
// Turns a 12-bit unsigned value into its Roman numeral, one ASCII letter
// per result transaction.
// ----------------------------------------------------------------------------
// A value goes in through push/full; its letters come out in reading order
// through empty/pop, one letter per transaction, with last set on the final
// letter. Zero is accepted and yields no letters; 4000 and up repeat M, so
// 4095 reads MMMMXCV. A short input queue sits in front of the sequencer, so
// new values are taken while an earlier one is still being spelled. The
// sequencer walks the thirteen greedy amounts in order: it loads a value,
// emits a letter each time an amount fits and moves past an amount that does not,
// until the remainder reaches zero (15 letters for 3888 is the longest
// numeral). Letters are produced no faster than the consumer pops them.
module roman_numeral_encoder_core
  import rne_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = RNE_QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [VALUE_W-1:0]  value,
  input  wire logic                push,
  output logic                     full,
  output logic [LETTER_W-1:0]      letter,
  output logic                     last,
  output logic                     empty,
  input  wire logic                pop
);

  rne_head_t head;
  logic      take;

  rne_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .value (value),
    .push  (push),
    .full  (full),
    .head  (head),
    .take  (take)
  );

  rne_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .take   (take),
    .letter (letter),
    .last   (last),
    .empty  (empty),
    .pop    (pop)
  );

endmodule
`default_nettype wire
